FILE: hdl/lrnac_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrnac_pkg: shared types and constants
// Register indexes, arithmetic widths and the status words passed between the
// window accumulator, the power unit and the core.
// ----------------------------------------------------------------------------
package lrnac_pkg;

    // Register indexes on the configuration port (byte address is 4 * index).
    localparam logic [2:0] REG_CHANNEL_COUNT = 3'd0;
    localparam logic [2:0] REG_PLANE_SIZE    = 3'd1;
    localparam logic [2:0] REG_HALF_WINDOW   = 3'd2;
    localparam logic [2:0] REG_ALPHA_SCALED  = 3'd3;
    localparam logic [2:0] REG_BETA_EXPONENT = 3'd4;
    localparam logic [2:0] REG_BIAS_TERM     = 3'd5;

    // Width of the window sum in Q.16: up to 15 terms below 2^30 + 2^24.
    localparam int SUM_W = 35;

    // Result of one window pass.
    typedef struct packed {
        logic               done;
        logic [SUM_W-1:0]   sum;
        logic signed [15:0] x;
    } win_result_t;

    // Result of one power evaluation.
    typedef struct packed {
        logic               done;
        logic signed [15:0] result;
    } pow_result_t;

endpackage

FILE: hdl/lrnac_window.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrnac_window: sample store and window accumulator
// Holds the recent channel planes in one synchronous memory and sums the
// squares plus bias over a run of channel slots at one pixel, one read a cycle.
// ----------------------------------------------------------------------------
module lrnac_window #(
    parameter int PLANE_MAX  = 1024,
    parameter int WINDOW_MAX = 15,
    parameter int SLOT_W     = 4,
    parameter int PX_W       = 10,
    parameter int ADDR_W     = 14
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  wr_en,
    input  logic [SLOT_W-1:0]     wr_slot,
    input  logic [PX_W-1:0]       wr_px,
    input  logic [15:0]           wr_data,
    input  logic                  go,
    input  logic [SLOT_W-1:0]     lo_slot,
    input  logic [3:0]            term_count,
    input  logic [3:0]            x_pos,
    input  logic [PX_W-1:0]       rd_px,
    input  logic [15:0]           bias,
    output lrnac_pkg::win_result_t res
);

    localparam int DEPTH = WINDOW_MAX * PLANE_MAX;
    localparam logic [ADDR_W-1:0] PLANE_A = ADDR_W'(PLANE_MAX);
    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(WINDOW_MAX - 1);

    logic [15:0] mem [0:DEPTH-1];
    logic [15:0] rd_data_reg;

    logic                       issue_reg;
    logic [SLOT_W-1:0]          slot_reg;
    logic [3:0]                 left_reg;
    logic [3:0]                 idx_reg;
    logic [3:0]                 xpos_reg;
    logic [PX_W-1:0]            px_reg;
    logic                       pend_reg;
    logic                       pend_last_reg;
    logic [3:0]                 pend_idx_reg;
    logic [lrnac_pkg::SUM_W-1:0] sum_reg;
    logic signed [15:0]         x_reg;
    logic                       done_reg;

    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] rd_addr;
    logic signed [15:0] y;
    logic signed [31:0] y_sq;
    logic [lrnac_pkg::SUM_W-1:0] term;

    assign wr_addr = ADDR_W'(wr_slot) * PLANE_A + ADDR_W'(wr_px);
    assign rd_addr = ADDR_W'(slot_reg) * PLANE_A + ADDR_W'(px_reg);

    // Store: one write port, one registered read port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (issue_reg) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Square of the returned sample plus the bias in Q.16.
    assign y    = rd_data_reg;
    assign y_sq = y * y;
    assign term = lrnac_pkg::SUM_W'(unsigned'(y_sq)) + (lrnac_pkg::SUM_W'(bias) << 8);

    // Read issue and accumulation.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            issue_reg <= 1'b0;
            pend_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            pend_reg <= 1'b0;
            if (go) begin
                issue_reg <= 1'b1;
                slot_reg  <= lo_slot;
                left_reg  <= term_count;
                idx_reg   <= 4'd0;
                xpos_reg  <= x_pos;
                px_reg    <= rd_px;
                sum_reg   <= '0;
            end else if (issue_reg) begin
                pend_reg      <= 1'b1;
                pend_idx_reg  <= idx_reg;
                pend_last_reg <= (left_reg == 4'd0);
                slot_reg      <= (slot_reg == SLOT_LAST) ? '0 : slot_reg + 1'b1;
                idx_reg       <= idx_reg + 4'd1;
                left_reg      <= left_reg - 4'd1;
                if (left_reg == 4'd0) begin
                    issue_reg <= 1'b0;
                end
            end
            if (pend_reg) begin
                sum_reg <= sum_reg + term;
                if (pend_idx_reg == xpos_reg) begin
                    x_reg <= y;
                end
                if (pend_last_reg) begin
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign res.done = done_reg;
    assign res.sum  = sum_reg;
    assign res.x    = x_reg;

endmodule

FILE: hdl/lrnac_power.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrnac_power: power unit
// Forms x * (1 + alpha*S)^(-beta) with a bit-serial log2, a chain of
// bit-serial square roots for exp2 and a saturating final scale.
// ----------------------------------------------------------------------------
module lrnac_power (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          go,
    input  logic [lrnac_pkg::SUM_W-1:0]   sum,
    input  logic signed [15:0]            x,
    input  logic [23:0]                   alpha,
    input  logic [15:0]                   beta,
    output lrnac_pkg::pow_result_t        res
);

    typedef enum logic [9:0] {
        P_IDLE  = 10'b0000000001,
        P_MLO   = 10'b0000000010,
        P_MHI   = 10'b0000000100,
        P_NORM  = 10'b0000001000,
        P_LOG   = 10'b0000010000,
        P_TMUL  = 10'b0000100000,
        P_PREP  = 10'b0001000000,
        P_SQRT  = 10'b0010000000,
        P_SHIFT = 10'b0100000000,
        P_SCALE = 10'b1000000000
    } pstate_t;

    pstate_t state_reg;

    logic [lrnac_pkg::SUM_W-1:0] s_reg;
    logic signed [15:0] x_reg;
    logic [40:0] plo_reg;
    logic [59:0] v_reg;
    logic [4:0]  cnt_reg;
    logic [30:0] m_reg;
    logic [15:0] frac_reg;
    logic [3:0]  it_reg;
    logic [22:0] t_reg;
    logic [3:0]  k_reg;
    logic [30:0] r_reg;
    logic [60:0] sn_reg;
    logic [61:0] rr_reg;
    logic [61:0] bit_reg;
    logic signed [15:0] res_reg;
    logic        done_reg;

    logic [40:0] prod_lo;
    logic [41:0] prod_hi;
    logic [61:0] m_sq;
    logic [31:0] m_next;
    logic [4:0]  int_part;
    logic [20:0] log_val;
    logic [36:0] t_prod;
    logic [61:0] trial;
    logic [61:0] rr_next;
    logic [6:0]  n_shift;
    logic [16:0] x_ext;
    logic [16:0] mag;
    logic [47:0] q_prod;
    logic [17:0] q;
    logic signed [15:0] res_sat;

    // Datapath pieces, one multiply per state.
    assign prod_lo  = alpha * s_reg[16:0];
    assign prod_hi  = alpha * s_reg[34:17];
    assign m_sq     = m_reg * m_reg;
    assign m_next   = m_sq[61:30];
    assign int_part = cnt_reg - 5'd10;
    assign log_val  = {int_part, frac_reg};
    assign t_prod   = beta * log_val + 37'd8192;
    assign trial    = rr_reg + bit_reg;
    assign rr_next  = ({1'b0, sn_reg} >= trial) ? ((rr_reg >> 1) + bit_reg) : (rr_reg >> 1);
    assign n_shift  = t_reg[22:16];

    // Rounded magnitude product and saturation to Q7.8.
    assign x_ext  = {x_reg[15], x_reg};
    assign mag    = x_reg[15] ? (17'd0 - x_ext) : x_ext;
    assign q_prod = mag * r_reg + 48'd536870912;
    assign q      = q_prod[47:30];
    always_comb begin
        if (x_reg[15]) begin
            res_sat = (q > 18'd32768) ? 16'sh8000 : 16'(18'd0 - q);
        end else begin
            res_sat = (q > 18'd32767) ? 16'sh7FFF : 16'(q);
        end
    end

    // Sequencer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= P_IDLE;
            done_reg  <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            unique case (state_reg)
                P_IDLE: begin
                    if (go) begin
                        s_reg     <= sum;
                        x_reg     <= x;
                        state_reg <= P_MLO;
                    end
                end
                P_MLO: begin
                    plo_reg   <= prod_lo;
                    state_reg <= P_MHI;
                end
                P_MHI: begin
                    v_reg     <= (60'd1 << 40) + 60'(plo_reg) + (60'(prod_hi) << 17);
                    cnt_reg   <= 5'd0;
                    state_reg <= P_NORM;
                end
                P_NORM: begin
                    if (|v_reg[59:39]) begin
                        v_reg   <= v_reg >> 8;
                        cnt_reg <= cnt_reg + 5'd8;
                    end else if (|v_reg[59:31]) begin
                        v_reg   <= v_reg >> 1;
                        cnt_reg <= cnt_reg + 5'd1;
                    end else begin
                        m_reg     <= v_reg[30:0];
                        frac_reg  <= 16'd0;
                        it_reg    <= 4'd0;
                        state_reg <= P_LOG;
                    end
                end
                P_LOG: begin
                    if (m_next[31]) begin
                        m_reg    <= m_next[31:1];
                        frac_reg <= {frac_reg[14:0], 1'b1};
                    end else begin
                        m_reg    <= m_next[30:0];
                        frac_reg <= {frac_reg[14:0], 1'b0};
                    end
                    it_reg <= it_reg + 4'd1;
                    if (it_reg == 4'd15) begin
                        state_reg <= P_TMUL;
                    end
                end
                P_TMUL: begin
                    t_reg     <= t_prod[36:14];
                    r_reg     <= 31'd1 << 30;
                    k_reg     <= 4'd0;
                    state_reg <= P_PREP;
                end
                P_PREP: begin
                    sn_reg    <= 61'(r_reg >> t_reg[k_reg]) << 30;
                    rr_reg    <= '0;
                    bit_reg   <= 62'd1 << 60;
                    state_reg <= P_SQRT;
                end
                P_SQRT: begin
                    if ({1'b0, sn_reg} >= trial) begin
                        sn_reg <= 61'({1'b0, sn_reg} - trial);
                    end
                    rr_reg  <= rr_next;
                    bit_reg <= bit_reg >> 2;
                    if (bit_reg[0]) begin
                        r_reg <= rr_next[30:0];
                        k_reg <= k_reg + 4'd1;
                        state_reg <= (k_reg == 4'd15) ? P_SHIFT : P_PREP;
                    end
                end
                P_SHIFT: begin
                    r_reg     <= (n_shift >= 7'd31) ? 31'd0 : (r_reg >> n_shift);
                    state_reg <= P_SCALE;
                end
                P_SCALE: begin
                    res_reg   <= res_sat;
                    done_reg  <= 1'b1;
                    state_reg <= P_IDLE;
                end
                default: state_reg <= P_IDLE;
            endcase
        end
    end

    assign res.done   = done_reg;
    assign res.result = res_reg;

endmodule

FILE: hdl/lrn_across_channels_core.sv
`timescale 1ns / 1ps
// Flow: one word is taken per input; each result element then takes a window pass
// and a power evaluation (the 16 bit-serial square roots dominate), then is emitted.
// Throughput: one element at a time; the next input word is taken only after the
// last element of the previous one has been loaded into the output register.
// Reset: aresetn is synchronous and active low; counters, configuration registers
// and control return to their reset values, the sample store keeps its contents.
// ----------------------------------------------------------------------------
// lrn_across_channels_core: local response normalization across channels
// Stream in, stream out, configuration over an APB-style port.
// ----------------------------------------------------------------------------
module lrn_across_channels_core #(
    parameter int PLANE_MAX   = 1024,
    parameter int WINDOW_MAX  = 15,
    parameter int CHANNEL_MAX = 1024
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Input stream. tdata: sample[15:0]
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,
    // Result stream. tdata: result[15:0], channel_index[25:16], pixel_index[35:26]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,
    output logic        m_tlast,
    // tuser: image_done[0]
    output logic        m_tuser,
    // Configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int SLOT_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int PX_W   = (PLANE_MAX > 1) ? $clog2(PLANE_MAX) : 1;
    localparam int ADDR_W = (WINDOW_MAX * PLANE_MAX > 1) ? $clog2(WINDOW_MAX * PLANE_MAX) : 1;
    localparam int CH_CAP = (CHANNEL_MAX < 1024) ? CHANNEL_MAX : 1024;
    localparam int PL_CAP = (PLANE_MAX < 1024) ? PLANE_MAX : 1024;
    localparam logic [2:0] HW_CAP = 3'((WINDOW_MAX - 1) / 2);
    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(WINDOW_MAX - 1);
    localparam logic [PX_W-1:0]   PXA_LAST  = PX_W'(PLANE_MAX - 1);
    localparam logic [4:0]        WIN_SPAN  = 5'(WINDOW_MAX);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_WIN  = 4'b0010,
        ST_POW  = 4'b0100,
        ST_EMIT = 4'b1000
    } state_t;

    // Configuration registers.
    logic [10:0] channel_count_reg;
    logic [10:0] plane_size_reg;
    logic [2:0]  half_window_reg;
    logic [23:0] alpha_scaled_reg;
    logic [15:0] beta_exponent_reg;
    logic [15:0] bias_term_reg;

    // Position counters.
    logic [9:0]        chan_cnt_reg;
    logic [SLOT_W-1:0] slot_cnt_reg;
    logic [9:0]        pix_cnt_reg;
    logic [PX_W-1:0]   pxa_cnt_reg;

    // Per-input context.
    state_t            state_reg;
    logic [9:0]        cur_c_reg;
    logic [SLOT_W-1:0] cur_slot_reg;
    logic [9:0]        cur_p_reg;
    logic [PX_W-1:0]   cur_pxa_reg;
    logic              cur_lastch_reg;
    logic              cur_lastpx_reg;
    logic [2:0]        hw_reg;
    logic [9:0]        e_reg;
    logic [9:0]        elast_reg;
    logic              win_go_reg;
    logic              pow_go_reg;

    // Output register.
    logic        m_tvalid_reg;
    logic [39:0] m_tdata_reg;
    logic        m_tlast_reg;
    logic        m_tuser_reg;

    logic        cfg_wr;
    logic        s_accept;
    logic [10:0] chans;
    logic [10:0] plane;
    logic [2:0]  hw_eff;
    logic        last_ch;
    logic        last_px;
    logic        produce;
    logic [9:0]  first_e;
    logic [9:0]  lo;
    logic [10:0] hi_try;
    logic [9:0]  hi;
    logic [3:0]  term_count;
    logic [3:0]  diff;
    logic [3:0]  x_pos;
    logic [4:0]  slot_up;
    logic [SLOT_W-1:0] lo_slot;
    logic        out_load;
    logic        elem_last;

    lrnac_pkg::win_result_t win_res;
    lrnac_pkg::pow_result_t pow_res;

    // Configuration port.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            channel_count_reg <= 11'd1;
            plane_size_reg    <= 11'd1;
            half_window_reg   <= 3'd2;
            alpha_scaled_reg  <= 24'd1677;
            beta_exponent_reg <= 16'd12288;
            bias_term_reg     <= 16'd256;
        end else if (cfg_wr) begin
            unique case (paddr[4:2])
                lrnac_pkg::REG_CHANNEL_COUNT: channel_count_reg <= pwdata[10:0];
                lrnac_pkg::REG_PLANE_SIZE:    plane_size_reg    <= pwdata[10:0];
                lrnac_pkg::REG_HALF_WINDOW:   half_window_reg   <= pwdata[2:0];
                lrnac_pkg::REG_ALPHA_SCALED:  alpha_scaled_reg  <= pwdata[23:0];
                lrnac_pkg::REG_BETA_EXPONENT: beta_exponent_reg <= pwdata[15:0];
                lrnac_pkg::REG_BIAS_TERM:     bias_term_reg     <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:2])
            lrnac_pkg::REG_CHANNEL_COUNT: prdata = 32'(channel_count_reg);
            lrnac_pkg::REG_PLANE_SIZE:    prdata = 32'(plane_size_reg);
            lrnac_pkg::REG_HALF_WINDOW:   prdata = 32'(half_window_reg);
            lrnac_pkg::REG_ALPHA_SCALED:  prdata = 32'(alpha_scaled_reg);
            lrnac_pkg::REG_BETA_EXPONENT: prdata = 32'(beta_exponent_reg);
            lrnac_pkg::REG_BIAS_TERM:     prdata = 32'(bias_term_reg);
            default:                      prdata = 32'd0;
        endcase
    end

    // Effective counts and window; zero counts act as one, too large values are capped.
    always_comb begin
        if (channel_count_reg == 11'd0) chans = 11'd1;
        else if (channel_count_reg > 11'(CH_CAP)) chans = 11'(CH_CAP);
        else chans = channel_count_reg;
        if (plane_size_reg == 11'd0) plane = 11'd1;
        else if (plane_size_reg > 11'(PL_CAP)) plane = 11'(PL_CAP);
        else plane = plane_size_reg;
    end

    assign hw_eff  = (half_window_reg > HW_CAP) ? HW_CAP : half_window_reg;
    assign last_ch = {1'b0, chan_cnt_reg} >= chans - 11'd1;
    assign last_px = {1'b0, pix_cnt_reg} >= plane - 11'd1;
    assign produce = (chan_cnt_reg >= 10'(hw_eff)) || last_ch;
    assign first_e = (chan_cnt_reg >= 10'(hw_eff)) ? chan_cnt_reg - 10'(hw_eff) : 10'd0;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;

    // Position counters advance once per accepted word.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chan_cnt_reg <= '0;
            slot_cnt_reg <= '0;
            pix_cnt_reg  <= '0;
            pxa_cnt_reg  <= '0;
        end else if (s_accept) begin
            if (last_px) begin
                pix_cnt_reg <= '0;
                pxa_cnt_reg <= '0;
                if (last_ch) begin
                    chan_cnt_reg <= '0;
                    slot_cnt_reg <= '0;
                end else begin
                    chan_cnt_reg <= chan_cnt_reg + 10'd1;
                    slot_cnt_reg <= (slot_cnt_reg == SLOT_LAST) ? '0 : slot_cnt_reg + 1'b1;
                end
            end else begin
                pix_cnt_reg <= pix_cnt_reg + 10'd1;
                pxa_cnt_reg <= (pxa_cnt_reg == PXA_LAST) ? '0 : pxa_cnt_reg + 1'b1;
            end
        end
    end

    // Window bounds of the current element and its first store slot.
    assign lo     = (e_reg >= 10'(hw_reg)) ? e_reg - 10'(hw_reg) : 10'd0;
    assign hi_try = {1'b0, e_reg} + 11'(hw_reg);
    assign hi     = (hi_try < {1'b0, cur_c_reg}) ? hi_try[9:0] : cur_c_reg;
    assign term_count = 4'(hi - lo);
    assign diff   = 4'(cur_c_reg - lo);
    assign x_pos  = 4'(e_reg - lo);
    assign slot_up = 5'(cur_slot_reg) + WIN_SPAN - 5'(diff);
    assign lo_slot = (5'(cur_slot_reg) >= 5'(diff)) ? SLOT_W'(5'(cur_slot_reg) - 5'(diff))
                                                    : SLOT_W'(slot_up);

    assign out_load  = (state_reg == ST_EMIT) && (!m_tvalid_reg || m_tready);
    assign elem_last = (e_reg == elast_reg);

    // Element sequencer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            win_go_reg <= 1'b0;
            pow_go_reg <= 1'b0;
        end else begin
            win_go_reg <= 1'b0;
            pow_go_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_accept) begin
                        cur_c_reg      <= chan_cnt_reg;
                        cur_slot_reg   <= slot_cnt_reg;
                        cur_p_reg      <= pix_cnt_reg;
                        cur_pxa_reg    <= pxa_cnt_reg;
                        cur_lastch_reg <= last_ch;
                        cur_lastpx_reg <= last_px;
                        hw_reg         <= hw_eff;
                        e_reg          <= first_e;
                        elast_reg      <= last_ch ? chan_cnt_reg : first_e;
                        if (produce) begin
                            state_reg  <= ST_WIN;
                            win_go_reg <= 1'b1;
                        end
                    end
                end
                ST_WIN: begin
                    if (win_res.done) begin
                        state_reg  <= ST_POW;
                        pow_go_reg <= 1'b1;
                    end
                end
                ST_POW: begin
                    if (pow_res.done) begin
                        state_reg <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    if (out_load) begin
                        if (elem_last) begin
                            state_reg <= ST_IDLE;
                        end else begin
                            e_reg      <= e_reg + 10'd1;
                            state_reg  <= ST_WIN;
                            win_go_reg <= 1'b1;
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // Output word register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_tdata_reg <= {4'd0, cur_p_reg, e_reg, pow_res.result};
            m_tlast_reg <= elem_last;
            m_tuser_reg <= elem_last && cur_lastch_reg && cur_lastpx_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tuser  = m_tuser_reg;

    lrnac_window #(
        .PLANE_MAX  (PLANE_MAX),
        .WINDOW_MAX (WINDOW_MAX),
        .SLOT_W     (SLOT_W),
        .PX_W       (PX_W),
        .ADDR_W     (ADDR_W)
    ) u_window (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .wr_en      (s_accept),
        .wr_slot    (slot_cnt_reg),
        .wr_px      (pxa_cnt_reg),
        .wr_data    (s_tdata),
        .go         (win_go_reg),
        .lo_slot    (lo_slot),
        .term_count (term_count),
        .x_pos      (x_pos),
        .rd_px      (cur_pxa_reg),
        .bias       (bias_term_reg),
        .res        (win_res)
    );

    lrnac_power u_power (
        .aclk    (aclk),
        .aresetn (aresetn),
        .go      (pow_go_reg),
        .sum     (win_res.sum),
        .x       (win_res.x),
        .alpha   (alpha_scaled_reg),
        .beta    (beta_exponent_reg),
        .res     (pow_res)
    );

`ifndef NO_ASSERTIONS
    // A window pass only starts while the sequencer waits for it.
    a_win_go_state: assert property (@(posedge aclk) disable iff (!aresetn)
        win_go_reg |-> state_reg == ST_WIN)
        else $error("window start outside window phase");

    // The power unit only finishes while the sequencer waits for it.
    a_pow_done_state: assert property (@(posedge aclk) disable iff (!aresetn)
        pow_res.done |-> state_reg == ST_POW)
        else $error("power result outside power phase");

    // Emitting the last element of an input returns to idle.
    a_last_to_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && elem_last) |=> state_reg == ST_IDLE)
        else $error("sequencer did not return to idle");

    // The image end marker only rides on the last word of a run.
    a_done_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> m_tlast)
        else $error("image end without run end");
`endif

endmodule
